// File: rtl/rmf_pkg.sv
// Package with the shared types, constants and helper functions of the RGB median filter.
`default_nettype none
package rmf_pkg;

  localparam int MAX_RADIUS   = 3;
  localparam int MAX_WIDTH    = 2048;
  localparam int HEIGHT_LIMIT = 2048;
  localparam int STORE_DEPTH  = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int WIN_MAX      = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int CNT_W        = $clog2(WIN_MAX + 1);
  localparam int DIM_W        = 12;
  localparam int COL_W        = 11;
  localparam int ITEM_W       = 23;
  localparam int DLY_W        = 14;
  localparam int IDX_W        = 2;

  localparam logic [IDX_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd2;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic       drain;
  } in_pix_t;

  typedef struct packed {
    logic [7:0] median_red;
    logic [7:0] median_green;
    logic [7:0] median_blue;
    logic       frame_last;
  } out_pix_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SETUP,
    ST_SCAN,
    ST_TAIL,
    ST_DECIDE,
    ST_OUT
  } ctl_state_t;

  typedef struct packed {
    logic latch;
    logic step;
    logic win_init;
    logic scan;
    logic bit_done;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_phase;
    logic item_drain;
    logic emit;
    logic last_elem;
    logic bit_zero;
    logic out_busy;
  } sts_t;

  // Rank of the median in a sorted window of side 2r+1.
  function automatic logic [CNT_W-1:0] win_rank(input logic [1:0] r);
    logic [CNT_W-1:0] res;
    case (r)
      2'd0:    res = CNT_W'(0);
      2'd1:    res = CNT_W'(4);
      2'd2:    res = CNT_W'(12);
      default: res = CNT_W'(24);
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

// File: rtl/rgb_median_filter_clamped_top.sv
// Top level of the RGB median filter with clamped square window.
//
// Usage: pixels enter in raster order on the in_ channel (valid/ready), one
// transaction per pixel. Window medians leave on the out_ channel, one result
// per transaction once r*W+r items have been taken in; after the last pixel of
// a frame the source sends r*W+r drain items to flush the tail.
// Configuration (radius, width, height) is written on the cfg_ channel, which
// is always ready; any write to those three restarts the frame counters.
// Items are handled one at a time. An item that yields a result holds the
// block until its result is loaded, while the single read port of the line
// store is swept once per median bit; the next item is taken in the cycle
// after the load. Items without a result go from EVAL straight back to IDLE.
// Reset returns the registers to r=1, W=640, H=480 and clears all counters;
// the line store is not cleared, since only pixels of the current frame are
// read. When the receiver stalls, the output register holds its result and
// the block still takes the next item, waiting only before loading the next one.
`default_nettype none
module rgb_median_filter_clamped_top (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  rmf_pkg::in_pix_t                in_data,
  output logic                            out_valid,
  input  wire                             out_ready,
  output rmf_pkg::out_pix_t               out_data,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [rmf_pkg::IDX_W-1:0]       cfg_index,
  input  wire  [rmf_pkg::DIM_W-1:0]       cfg_data
);

  rmf_pkg::cmd_t cmd;
  rmf_pkg::sts_t sts;

  // Register writes must only be issued while idle (the block does not enforce this); the port never stalls.
  assign cfg_ready = 1'b1;

  rmf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rmf_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire

// File: rtl/rmf_ctrl.sv
// Controller state machine that sequences one transaction through the datapath.
`default_nettype none
module rmf_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  rmf_pkg::sts_t        sts,
  output rmf_pkg::cmd_t        cmd
);

  rmf_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rmf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      rmf_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
        if (in_valid) begin
          state_nxt = rmf_pkg::ST_EVAL;
        end
      end
      rmf_pkg::ST_EVAL: begin
        // An early drain is dropped without touching the counters or the line store.
        if (sts.in_phase && sts.item_drain) begin
          state_nxt = rmf_pkg::ST_IDLE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = sts.emit ? rmf_pkg::ST_SETUP : rmf_pkg::ST_IDLE;
        end
      end
      rmf_pkg::ST_SETUP: begin
        cmd.win_init = 1'b1;
        state_nxt    = rmf_pkg::ST_SCAN;
      end
      rmf_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.last_elem) begin
          state_nxt = rmf_pkg::ST_TAIL;
        end
      end
      rmf_pkg::ST_TAIL: begin
        state_nxt = rmf_pkg::ST_DECIDE;
      end
      rmf_pkg::ST_DECIDE: begin
        cmd.bit_done = 1'b1;
        state_nxt    = sts.bit_zero ? rmf_pkg::ST_OUT : rmf_pkg::ST_SETUP;
      end
      rmf_pkg::ST_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = rmf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rmf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/rmf_datapath.sv
// Datapath: configuration registers, raster counters, line store, window scan and median search.
`default_nettype none
module rmf_datapath (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_valid,
  input  wire  [rmf_pkg::IDX_W-1:0]           cfg_index,
  input  wire  [rmf_pkg::DIM_W-1:0]           cfg_data,
  input  rmf_pkg::in_pix_t                    in_data,
  input  wire                                 out_ready,
  output logic                                out_valid,
  output rmf_pkg::out_pix_t                   out_data,
  input  rmf_pkg::cmd_t                       cmd,
  output rmf_pkg::sts_t                       sts
);

  localparam int AW = rmf_pkg::ADDR_W;
  localparam logic [AW:0] DEPTH = (AW+1)'(rmf_pkg::STORE_DEPTH);

  // Configuration registers.
  logic [1:0]                  radius_r;
  logic [rmf_pkg::DIM_W-1:0]   width_r, height_r;
  logic [1:0]                  r_eff;
  logic [rmf_pkg::DIM_W-1:0]   w_eff, h_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 2'd1;
      width_r  <= 12'd640;
      height_r <= 12'd480;
    end else if (cfg_valid) begin
      case (cfg_index)
        rmf_pkg::REG_RADIUS: radius_r <= cfg_data[1:0];
        rmf_pkg::REG_WIDTH:  width_r  <= cfg_data;
        rmf_pkg::REG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic cfg_hit;
  assign cfg_hit = cfg_valid && (cfg_index == rmf_pkg::REG_RADIUS ||
                                 cfg_index == rmf_pkg::REG_WIDTH ||
                                 cfg_index == rmf_pkg::REG_HEIGHT);

  always_comb begin
    r_eff = (32'(radius_r) > rmf_pkg::MAX_RADIUS) ? 2'(rmf_pkg::MAX_RADIUS) : radius_r;
    if (width_r == '0) begin
      w_eff = 12'd1;
    end else if (32'(width_r) > rmf_pkg::MAX_WIDTH) begin
      w_eff = 12'(rmf_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r == '0) begin
      h_eff = 12'd1;
    end else if (32'(height_r) > rmf_pkg::HEIGHT_LIMIT) begin
      h_eff = 12'(rmf_pkg::HEIGHT_LIMIT);
    end else begin
      h_eff = height_r;
    end
  end

  // Frame sizes, registered every cycle.
  logic [rmf_pkg::ITEM_W-1:0]  prod;
  logic [rmf_pkg::DLY_W-1:0]   dly_nxt;
  logic [rmf_pkg::ITEM_W-1:0]  npix_r, total_r;
  logic [rmf_pkg::DLY_W-1:0]   dly_r;

  assign prod    = rmf_pkg::ITEM_W'(w_eff) * rmf_pkg::ITEM_W'(h_eff);
  assign dly_nxt = {12'b0, r_eff} * {2'b0, w_eff} + {12'b0, r_eff};

  always_ff @(posedge clk) begin
    npix_r  <= prod;
    dly_r   <= dly_nxt;
    total_r <= prod + rmf_pkg::ITEM_W'(dly_nxt);
  end

  // Item latch and raster counters.
  rmf_pkg::in_pix_t            pix_r;
  logic [rmf_pkg::ITEM_W-1:0]  items_r, items_inc;
  logic [rmf_pkg::COL_W-1:0]   in_col_r, out_col_r, out_row_r;
  logic [AW-1:0]               wr_addr_r, ob_r;
  logic                        in_phase, restart;
  logic [rmf_pkg::DIM_W-1:0]   in_col_inc, out_col_inc;
  logic [AW:0]                 wr_inc, ob_add;

  assign items_inc   = items_r + 1'b1;
  assign in_phase    = items_r < npix_r;
  assign in_col_inc  = {1'b0, in_col_r} + 1'b1;
  assign out_col_inc = {1'b0, out_col_r} + 1'b1;
  assign wr_inc      = {1'b0, wr_addr_r} + 1'b1;
  assign ob_add      = {1'b0, ob_r} + (AW+1)'(w_eff);
  assign restart     = cfg_hit || (cmd.out_load && items_r >= total_r);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      pix_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      items_r   <= '0;
      in_col_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      wr_addr_r <= '0;
      ob_r      <= '0;
    end else if (restart) begin
      items_r   <= '0;
      in_col_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      wr_addr_r <= '0;
      ob_r      <= '0;
    end else begin
      if (cmd.step) begin
        items_r <= items_inc;
        if (in_phase) begin
          wr_addr_r <= (wr_inc >= DEPTH) ? '0 : wr_inc[AW-1:0];
          if (in_col_inc >= w_eff) begin
            in_col_r <= '0;
          end else begin
            in_col_r <= in_col_inc[rmf_pkg::COL_W-1:0];
          end
        end
      end
      if (cmd.out_load) begin
        if (out_col_inc >= w_eff) begin
          out_col_r <= '0;
          out_row_r <= out_row_r + 1'b1;
          ob_r      <= (ob_add >= DEPTH) ? AW'(ob_add - DEPTH) : ob_add[AW-1:0];
        end else begin
          out_col_r <= out_col_inc[rmf_pkg::COL_W-1:0];
        end
      end
    end
  end

  // Window scan.
  logic [AW-1:0]              rowbase_r;
  logic [rmf_pkg::COL_W-1:0]  yy_r;
  logic [2:0]                 dx_r, dy_r, side_m1;
  logic [rmf_pkg::COL_W-1:0]  yy0;
  logic [1:0]                 ydiff;
  logic [13:0]                mback;
  logic [AW:0]                rb_init, rb_step, rd_sum;
  logic [rmf_pkg::DIM_W-1:0]  xt, xx, yt, yy_next;
  logic [AW-1:0]              rd_addr;

  assign side_m1 = {r_eff, 1'b0};

  always_comb begin
    yy0     = (out_row_r >= rmf_pkg::COL_W'(r_eff)) ? out_row_r - rmf_pkg::COL_W'(r_eff) : '0;
    ydiff   = 2'(out_row_r - yy0);
    mback   = {12'b0, ydiff} * {2'b0, w_eff};
    rb_init = (ob_r >= AW'(mback)) ? (AW+1)'(ob_r - AW'(mback))
                                   : (AW+1)'({1'b0, ob_r} + DEPTH - (AW+1)'(mback));
    rb_step = {1'b0, rowbase_r} + (AW+1)'(w_eff);
    xt      = {1'b0, out_col_r} + rmf_pkg::DIM_W'(dx_r);
    xx      = (xt < rmf_pkg::DIM_W'(r_eff)) ? '0 : xt - rmf_pkg::DIM_W'(r_eff);
    if (xx >= w_eff) begin
      xx = w_eff - 1'b1;
    end
    yt      = {1'b0, out_row_r} + rmf_pkg::DIM_W'(dy_r) + 1'b1;
    yy_next = (yt < rmf_pkg::DIM_W'(r_eff)) ? '0 : yt - rmf_pkg::DIM_W'(r_eff);
    if (yy_next >= h_eff) begin
      yy_next = h_eff - 1'b1;
    end
    rd_sum  = {1'b0, rowbase_r} + (AW+1)'(xx);
    rd_addr = (rd_sum >= DEPTH) ? AW'(rd_sum - DEPTH) : rd_sum[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dx_r      <= '0;
      dy_r      <= '0;
      yy_r      <= '0;
      rowbase_r <= '0;
    end else if (cmd.win_init) begin
      dx_r      <= '0;
      dy_r      <= '0;
      yy_r      <= yy0;
      rowbase_r <= rb_init[AW-1:0];
    end else if (cmd.scan) begin
      if (dx_r == side_m1) begin
        dx_r <= '0;
        dy_r <= dy_r + 1'b1;
        if (yy_next != {1'b0, yy_r}) begin
          yy_r      <= yy_next[rmf_pkg::COL_W-1:0];
          rowbase_r <= (rb_step >= DEPTH) ? AW'(rb_step - DEPTH) : rb_step[AW-1:0];
        end
      end else begin
        dx_r <= dx_r + 1'b1;
      end
    end
  end

  // Line store.
  logic [23:0] mem [rmf_pkg::STORE_DEPTH];
  logic [23:0] rdata_r;
  logic        rvld_r;

  always_ff @(posedge clk) begin
    if (cmd.step && in_phase) begin
      mem[wr_addr_r] <= {pix_r.in_red, pix_r.in_green, pix_r.in_blue};
    end
    if (cmd.scan) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvld_r <= 1'b0;
    end else begin
      rvld_r <= cmd.scan;
    end
  end

  // Bitwise median search, three channels in parallel.
  logic [7:0]                v_r   [3];
  logic [rmf_pkg::CNT_W-1:0] cnt_r [3];
  logic [7:0]                cand  [3];
  logic [2:0]                bit_r;
  logic [rmf_pkg::CNT_W-1:0] rank;

  assign rank = rmf_pkg::win_rank(r_eff);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      cand[c] = v_r[c] | (8'd1 << bit_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= 3'd7;
      for (int c = 0; c < 3; c++) begin
        v_r[c]   <= '0;
        cnt_r[c] <= '0;
      end
    end else if (cmd.step) begin
      bit_r <= 3'd7;
      for (int c = 0; c < 3; c++) begin
        v_r[c]   <= '0;
        cnt_r[c] <= '0;
      end
    end else if (cmd.bit_done) begin
      bit_r <= bit_r - 1'b1;
      for (int c = 0; c < 3; c++) begin
        cnt_r[c] <= '0;
        if (cnt_r[c] <= rank) begin
          v_r[c] <= cand[c];
        end
      end
    end else if (rvld_r) begin
      for (int c = 0; c < 3; c++) begin
        if (rdata_r[23 - 8 * c -: 8] < cand[c]) begin
          cnt_r[c] <= cnt_r[c] + 1'b1;
        end
      end
    end
  end

  // Output register.
  logic              out_valid_r;
  rmf_pkg::out_pix_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.median_red   <= v_r[0];
      out_r.median_green <= v_r[1];
      out_r.median_blue  <= v_r[2];
      out_r.frame_last   <= ({1'b0, out_row_r} == h_eff - 1'b1) &&
                            ({1'b0, out_col_r} == w_eff - 1'b1);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    sts.in_phase   = in_phase;
    sts.item_drain = pix_r.drain;
    sts.emit       = items_inc > rmf_pkg::ITEM_W'(dly_r);
    sts.last_elem  = (dx_r == side_m1) && (dy_r == side_m1);
    sts.bit_zero   = (bit_r == 3'd0);
    sts.out_busy   = out_valid_r && !out_ready;
  end

  a_wr_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (AW+1)'(wr_addr_r) < DEPTH) else $error("write address out of range");
  a_rowbase_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> (AW+1)'(rowbase_r) < DEPTH) else $error("row base out of range");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.bit_done |-> 32'(cnt_r[0]) <= rmf_pkg::WIN_MAX) else $error("count overflow");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && !out_ready)) else $error("result overwritten");

endmodule
`default_nettype wire

// File: test/rgb_median_filter_clamped_top_tb.sv
// Self-checking testbench for the clamped-window RGB median filter.
`default_nettype none
module rgb_median_filter_clamped_top_tb;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int IDLE_PCT = 23;
  localparam int HOLD_CYCLES = 1500;
  localparam int RANDOM_ITEMS = 1000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  rmf_pkg::in_pix_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rmf_pkg::out_pix_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rmf_pkg::IDX_W-1:0] cfg_index = rmf_pkg::REG_RADIUS;
  logic [rmf_pkg::DIM_W-1:0] cfg_data = '0;

  rgb_median_filter_clamped_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Pixels waiting to be offered, and medians the block still owes us.
  rmf_pkg::in_pix_t pix_q[$];
  rmf_pkg::out_pix_t median_q[$];

  // Stimulus controls: steady turns idling off on both sides, hold_req asks
  // the receiver for one long stall.
  bit steady = 1'b0;
  bit hold_req = 1'b0;
  int errors = 0;
  int items_taken = 0;
  int medians_seen = 0;
  int reg_writes = 0;
  int cycles = 0;

  // Predictor state: its own copy of the registers, the raster counters and
  // the line store.
  logic [1:0] radius_reg;
  logic [11:0] width_reg, height_reg;
  int col_in, row_in, col_out, row_out, item_count;
  logic [23:0] pix_mem [rmf_pkg::STORE_DEPTH];

  function automatic int eff_radius(logic [1:0] r);
    return (r > rmf_pkg::MAX_RADIUS) ? rmf_pkg::MAX_RADIUS : int'(r);
  endfunction

  function automatic int eff_dim(logic [11:0] v, int lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : int'(v);
  endfunction

  function automatic int clamp_to(int v, int lim);
    if (v < 0) return 0;
    if (v >= lim) return lim - 1;
    return v;
  endfunction

  task automatic restart_frame();
    col_in = 0; row_in = 0; col_out = 0; row_out = 0; item_count = 0;
  endtask

  task automatic apply_reg(logic [rmf_pkg::IDX_W-1:0] idx, logic [rmf_pkg::DIM_W-1:0] val);
    case (idx)
      rmf_pkg::REG_RADIUS: radius_reg = val[1:0];
      rmf_pkg::REG_WIDTH:  width_reg = val;
      rmf_pkg::REG_HEIGHT: height_reg = val;
      default: return;
    endcase
    restart_frame();
  endtask

  // Advances the predictor by one accepted transaction and queues the median
  // that it causes, if any.
  task automatic filter_pixel(rmf_pkg::in_pix_t p);
    int r, w, h, npix, delay, oy, ox, yy, xx, addr, rank, cum, c;
    int hist [3][256];
    logic [23:0] px;
    rmf_pkg::out_pix_t res;
    r = eff_radius(radius_reg);
    w = eff_dim(width_reg, rmf_pkg::MAX_WIDTH);
    h = eff_dim(height_reg, rmf_pkg::HEIGHT_LIMIT);
    npix = w * h;
    delay = r * w + r;
    if (item_count < npix) begin
      // A drain that shows up while pixels are still due is dropped.
      if (p.drain) return;
      pix_mem[(row_in * w + col_in) % rmf_pkg::STORE_DEPTH] = {p.in_red, p.in_green, p.in_blue};
      col_in++;
      if (col_in >= w) begin
        col_in = 0;
        row_in++;
      end
    end
    item_count++;
    if (item_count <= delay) return;
    oy = (row_out < h) ? row_out : h - 1;
    ox = (col_out < w) ? col_out : w - 1;
    for (int c0 = 0; c0 < 3; c0++)
      for (int v = 0; v < 256; v++) hist[c0][v] = 0;
    for (int dy = -r; dy <= r; dy++) begin
      yy = clamp_to(oy + dy, h);
      for (int dx = -r; dx <= r; dx++) begin
        xx = clamp_to(ox + dx, w);
        addr = (yy * w + xx) % rmf_pkg::STORE_DEPTH;
        px = pix_mem[addr];
        hist[0][px[23:16]]++;
        hist[1][px[15:8]]++;
        hist[2][px[7:0]]++;
      end
    end
    rank = ((2 * r + 1) * (2 * r + 1)) / 2;
    res = '0;
    for (c = 0; c < 3; c++) begin
      logic [7:0] med;
      med = 8'hFF;
      cum = 0;
      for (int v = 0; v < 256; v++) begin
        cum += hist[c][v];
        if (cum > rank) begin
          med = v[7:0];
          break;
        end
      end
      case (c)
        0: res.median_red = med;
        1: res.median_green = med;
        default: res.median_blue = med;
      endcase
    end
    res.frame_last = (oy == h - 1) && (ox == w - 1);
    median_q.push_back(res);
    col_out++;
    if (col_out >= w) begin
      col_out = 0;
      row_out++;
    end
    if (item_count >= npix + delay) restart_frame();
  endtask

  // Driver: tracks accepted transactions on the input and config channels and
  // offers the next pending pixel, idling now and then unless told not to.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        apply_reg(cfg_index, cfg_data);
        reg_writes++;
      end
      if (in_valid && in_ready) begin
        filter_pixel(in_data);
        items_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pix_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          in_data <= pix_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction against the oldest expected
  // median and drives out_ready, including the one long requested stall.
  int hold_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        medians_seen++;
        if (median_q.size() == 0) begin
          $error("unexpected result transaction: %p", out_data);
          errors++;
        end else begin
          rmf_pkg::out_pix_t exp_pix;
          exp_pix = median_q.pop_front();
          if (out_data.median_red !== exp_pix.median_red) begin
            $error("median_red expected %0d actual %0d",
                   exp_pix.median_red, out_data.median_red);
            errors++;
          end
          if (out_data.median_green !== exp_pix.median_green) begin
            $error("median_green expected %0d actual %0d",
                   exp_pix.median_green, out_data.median_green);
            errors++;
          end
          if (out_data.median_blue !== exp_pix.median_blue) begin
            $error("median_blue expected %0d actual %0d",
                   exp_pix.median_blue, out_data.median_blue);
            errors++;
          end
          if (out_data.frame_last !== exp_pix.frame_last) begin
            $error("frame_last expected %0d actual %0d",
                   exp_pix.frame_last, out_data.frame_last);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
        if (hold_left == 1) hold_req <= 1'b0;
      end else if (hold_req) begin
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("rgb_median_filter_clamped_top test failed");
      $finish;
    end
  end

  task automatic write_reg(logic [rmf_pkg::IDX_W-1:0] idx, logic [rmf_pkg::DIM_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic setup_regs(logic [1:0] r, logic [11:0] w, logic [11:0] h);
    write_reg(rmf_pkg::REG_RADIUS, {10'd0, r});
    write_reg(rmf_pkg::REG_WIDTH, w);
    write_reg(rmf_pkg::REG_HEIGHT, h);
  endtask

  // Lets everything in flight drain out. Items without a result leave no median
  // to wait for, so a short extra pause covers them.
  task automatic wait_quiet();
    do @(negedge clk); while (pix_q.size() != 0 || in_valid || median_q.size() != 0);
    repeat (10) @(negedge clk);
  endtask

  task automatic push_pix(bit drain, logic [23:0] rgb);
    rmf_pkg::in_pix_t p;
    p.in_red = rgb[23:16];
    p.in_green = rgb[15:8];
    p.in_blue = rgb[7:0];
    p.drain = drain;
    pix_q.push_back(p);
  endtask

  // Queues one frame for the given register values. A noisy frame gets stray
  // drains among its pixels and colored items among its drains.
  task automatic push_frame(logic [1:0] r, logic [11:0] w, logic [11:0] h, bit noisy,
                            ref int n);
    int npix, delay;
    npix = eff_dim(w, rmf_pkg::MAX_WIDTH) * eff_dim(h, rmf_pkg::HEIGHT_LIMIT);
    delay = eff_radius(r) * eff_dim(w, rmf_pkg::MAX_WIDTH) + eff_radius(r);
    for (int i = 0; i < npix; i++) begin
      if (noisy && $urandom_range(9) == 0) push_pix(1'b1, 24'($urandom));
      push_pix(1'b0, 24'($urandom));
      n++;
    end
    for (int i = 0; i < delay; i++) begin
      push_pix(!(noisy && $urandom_range(3) == 0), 24'($urandom));
      n++;
    end
  endtask

  initial begin
    int n;
    logic [1:0] r;
    logic [11:0] w, h;
    n = 0;
    radius_reg = 2'd1;
    width_reg = 12'd640;
    height_reg = 12'd480;
    restart_frame();
    for (int i = 0; i < rmf_pkg::STORE_DEPTH; i++) pix_mem[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: a 3x2 frame at radius 1 with color extremes, a drain inside
    // the frame that must be ignored, and a colored item among the tail
    // drains that must be treated as a drain.
    setup_regs(2'd1, 12'd3, 12'd2);
    push_pix(1'b0, 24'h000000);
    push_pix(1'b0, 24'hFFFFFF);
    push_pix(1'b1, 24'h123456);
    push_pix(1'b0, 24'hFF00FF);
    push_pix(1'b0, 24'h00FF00);
    push_pix(1'b0, 24'hAA55AA);
    push_pix(1'b0, 24'h55AA55);
    push_pix(1'b1, 24'h0);
    push_pix(1'b0, 24'hFFFFFF);
    push_pix(1'b1, 24'h0);
    push_pix(1'b1, 24'h0);
    wait_quiet();
    // Zero width and height act as a 1x1 frame; two frames back to back
    // check the automatic restart at frame end.
    setup_regs(2'd0, 12'd0, 12'd0);
    push_pix(1'b0, 24'hFFFFFF);
    push_pix(1'b0, 24'h000000);
    wait_quiet();
    // An out-of-range register index must leave the frame position alone.
    setup_regs(2'd1, 12'd2, 12'd2);
    push_pix(1'b0, 24'h102030);
    push_pix(1'b0, 24'h405060);
    wait_quiet();
    write_reg(2'd3, 12'hFFF);
    push_pix(1'b0, 24'h708090);
    push_pix(1'b0, 24'hA0B0C0);
    repeat (3) push_pix(1'b1, 24'h0);
    wait_quiet();
    // A partial frame cut short by a register write.
    setup_regs(2'd2, 12'd4, 12'd3);
    push_pix(1'b0, 24'hFEDCBA);
    push_pix(1'b0, 24'h012345);
    wait_quiet();
    n = 0;

    // Random phases: mostly well-formed frames of small size, some noisy or
    // cut short, with the largest radius now and then. The phase with the
    // long receiver stall uses a frame big enough to back up the input.
    for (int ph = 0; n < RANDOM_ITEMS; ph++) begin
      r = ($urandom_range(5) == 0) ? 2'd3 : 2'($urandom_range(2));
      w = ($urandom_range(9) == 0) ? 12'd0 : 12'($urandom_range(1, (r == 3) ? 8 : 12));
      h = ($urandom_range(9) == 0) ? 12'd0 : 12'($urandom_range(1, 5));
      if (ph == 2) begin
        r = 2'd1;
        w = 12'd8;
        h = 12'd4;
      end
      steady = (ph >= 4 && ph < 8);
      setup_regs(r, w, h);
      if ($urandom_range(7) == 0) write_reg(2'd3, 12'($urandom));
      if (ph == 2) hold_req = 1'b1;
      for (int f = $urandom_range(1, 3); f > 0; f--)
        push_frame(r, w, h, $urandom_range(4) == 0, n);
      if ($urandom_range(5) == 0) begin
        for (int i = $urandom_range(1, 6); i > 0; i--) begin
          push_pix(1'($urandom_range(1)), 24'($urandom));
          n++;
        end
      end
      wait_quiet();
    end
    steady = 1'b0;

    wait_quiet();
    repeat (450) @(negedge clk);
    if (median_q.size() != 0) begin
      $error("%0d expected medians never arrived", median_q.size());
      errors++;
    end
    $display("covered %0d input transactions, %0d medians checked, %0d register writes",
             items_taken, medians_seen, reg_writes);
    $display("radius 0..3, zero and small frame sizes, noisy and cut-short frames, stalls");
    if (errors == 0) begin
      $display("rgb_median_filter_clamped_top test passed");
    end else begin
      $display("rgb_median_filter_clamped_top test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
rtl/rmf_pkg.sv
rtl/rmf_ctrl.sv
rtl/rmf_datapath.sv
rtl/rgb_median_filter_clamped_top.sv
test/rgb_median_filter_clamped_top_tb.sv
